// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TWS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("three wire serial master assertion failed");

// Check that a condition implies a consequence on the next clock.
`define TWS_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("three wire serial master assertion failed");

`endif

// ----- rtl/tws_pkg.sv -----
// Package with codes, constants and types of the three-wire serial master.
`timescale 1ns / 1ps
`default_nettype none
package tws_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIT_W   = 3;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CMD  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DATA = 2'd2;

  localparam logic [BIT_W-1:0]  LAST_BIT         = 3'd7;
  localparam logic [BYTE_W-1:0] HALF_PERIOD_RST  = 8'h01;
  localparam logic [BYTE_W-1:0] HALF_PERIOD_MIN  = 8'h01;

  typedef struct packed {
    logic              kind;
    logic              is_read;
    logic [BYTE_W-1:0] command_byte;
    logic [BYTE_W-1:0] write_data;
    logic              io_in;
  } tws_item_t;

  typedef struct packed {
    logic              chip_enable;
    logic              serial_clock;
    logic              io_out;
    logic              io_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
  } tws_result_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [BIT_W-1:0]   bit_count;
    logic               clock_level;
    logic [BYTE_W-1:0]  prescale_count;
    logic [BYTE_W-1:0]  command_shift;
    logic [BYTE_W-1:0]  data_shift;
    logic               read_mode;
    logic [BYTE_W-1:0]  received_byte;
  } tws_state_t;

endpackage
`default_nettype wire

// ----- rtl/tws_stream_if.sv -----
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
`default_nettype none
interface tws_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic                      is_read;
  logic [tws_pkg::BYTE_W-1:0] command_byte;
  logic [tws_pkg::BYTE_W-1:0] write_data;
  logic                      io_in;

  modport source (output valid, kind, is_read, command_byte, write_data, io_in,
                  input ready);
  modport sink   (input valid, kind, is_read, command_byte, write_data, io_in,
                  output ready);
endinterface

interface tws_out_if;
  logic                      valid;
  logic                      ready;
  logic                      chip_enable;
  logic                      serial_clock;
  logic                      io_out;
  logic                      io_drive;
  logic                      busy_res;
  logic                      done_res;
  logic [tws_pkg::BYTE_W-1:0] read_data;

  modport source (output valid, chip_enable, serial_clock, io_out, io_drive,
                  busy_res, done_res, read_data, input ready);
  modport sink   (input valid, chip_enable, serial_clock, io_out, io_drive,
                  busy_res, done_res, read_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/tws_cfg_regs.sv -----
// APB-style register holding the clock half period.
`timescale 1ns / 1ps
`default_nettype none
module tws_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [tws_pkg::PADDR_W-1:0] cfg_paddr,
  input  wire logic [tws_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic      [tws_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready,
  output logic      [tws_pkg::BYTE_W-1:0]  half_period_ticks
);
  import tws_pkg::*;

  logic [BYTE_W-1:0] half_period_r;
  logic              wr_en;

  // The only register spans the whole (word-sized) address range.
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[1:0] == 2'b00
                      || cfg_paddr[1:0] != 2'b00);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(PDATA_W-BYTE_W){1'b0}}, half_period_r};
  assign half_period_ticks = half_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
    end else if (wr_en) begin
      half_period_r <= cfg_pwdata[BYTE_W-1:0];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tws_engine.sv -----
// Access state register and its one-item update.
`timescale 1ns / 1ps
`default_nettype none
module tws_engine (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire tws_pkg::tws_item_t         item,
  input  wire logic [tws_pkg::BYTE_W-1:0] half_period_ticks,
  output tws_pkg::tws_result_t            res
);
  import tws_pkg::*;

  tws_state_t        st_r;
  tws_state_t        st_nxt;
  logic              done;
  logic [BYTE_W-1:0] limit;
  logic [BYTE_W:0]   pre_inc;

  // A zero half period behaves as one tick.
  assign limit   = (half_period_ticks == '0) ? HALF_PERIOD_MIN : half_period_ticks;
  assign pre_inc = {1'b0, st_r.prescale_count} + {{BYTE_W{1'b0}}, 1'b1};

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    if (item.kind) begin
      // Ignore a start while an access runs.
      if (st_r.phase == PH_IDLE) begin
        st_nxt.phase          = PH_CMD;
        st_nxt.bit_count      = '0;
        st_nxt.clock_level    = 1'b0;
        st_nxt.prescale_count = '0;
        st_nxt.read_mode      = item.is_read;
        st_nxt.command_shift  = item.command_byte;
        st_nxt.data_shift     = item.is_read ? '0 : item.write_data;
      end
    end else if (st_r.phase != PH_IDLE) begin
      if (pre_inc >= {1'b0, limit}) begin
        st_nxt.prescale_count = '0;
        if (!st_r.clock_level) begin
          // Rising edge: sample read data.
          if (st_r.phase == PH_DATA && st_r.read_mode) begin
            st_nxt.data_shift = {item.io_in, st_r.data_shift[BYTE_W-1:1]};
          end
          st_nxt.clock_level = 1'b1;
        end else begin
          // Falling edge: advance the driven bit.
          st_nxt.clock_level = 1'b0;
          if (st_r.phase == PH_CMD) begin
            st_nxt.command_shift = {1'b0, st_r.command_shift[BYTE_W-1:1]};
          end else if (!st_r.read_mode) begin
            st_nxt.data_shift = {1'b0, st_r.data_shift[BYTE_W-1:1]};
          end
          if (st_r.bit_count != LAST_BIT) begin
            st_nxt.bit_count = st_r.bit_count + 3'd1;
          end else begin
            st_nxt.bit_count = '0;
            unique case (st_r.phase)
              PH_CMD: begin
                st_nxt.phase = PH_DATA;
              end
              PH_DATA: begin
                if (st_r.read_mode) begin
                  st_nxt.received_byte = st_r.data_shift;
                end
                st_nxt.phase = PH_IDLE;
                done         = 1'b1;
              end
              default: begin
                st_nxt.phase = PH_IDLE;
              end
            endcase
          end
        end
      end else begin
        st_nxt.prescale_count = pre_inc[BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    res.chip_enable  = (st_nxt.phase != PH_IDLE);
    res.busy_res     = (st_nxt.phase != PH_IDLE);
    res.serial_clock = st_nxt.clock_level;
    res.done_res     = done;
    res.read_data    = st_nxt.received_byte;
    res.io_drive     = 1'b0;
    res.io_out       = 1'b0;
    if (st_nxt.phase == PH_CMD) begin
      res.io_drive = 1'b1;
      res.io_out   = st_nxt.command_shift[0];
    end else if (st_nxt.phase == PH_DATA && !st_nxt.read_mode) begin
      res.io_drive = 1'b1;
      res.io_out   = st_nxt.data_shift[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/three_wire_serial_master.sv -----
// Top level of the three-wire serial master: channels, register port, result register.
//
//   channel   direction   transfer
//   in_chan   sink        one tick or start item per transfer
//   out_chan  source      one result per accepted item, same order
//   cfg_*     APB slave   half_period_ticks at byte address 0
//
// Each item is processed on the clock edge that accepts it: the access state updates
// on that edge and its result lands in the output register on the same edge.
// The output register sets the rate: a new item enters every cycle while the
// result sink takes results or the register is empty.
// Reset (rst_n low, synchronous) idles the link and sets the half period to 1.
// A stalled result holds in the output register and blocks input only then.
`timescale 1ns / 1ps
`default_nettype none
module three_wire_serial_master (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  tws_in_if.sink                           in_chan,
  tws_out_if.source                        out_chan,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [tws_pkg::PADDR_W-1:0] cfg_paddr,
  input  wire logic [tws_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic      [tws_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import tws_pkg::*;

  logic              in_ready;
  logic              accept;
  logic [BYTE_W-1:0] half_period_ticks;
  tws_item_t         item;
  tws_result_t       res;
  tws_result_t       res_r;
  logic              out_valid_r;

  // Take an item when the result register is empty or drains this cycle.
  assign in_ready      = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  // Gather the item fields into one word.
  assign item.kind         = in_chan.kind;
  assign item.is_read      = in_chan.is_read;
  assign item.command_byte = in_chan.command_byte;
  assign item.write_data   = in_chan.write_data;
  assign item.io_in        = in_chan.io_in;

  tws_cfg_regs u_cfg (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .half_period_ticks (half_period_ticks)
  );

  tws_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .item              (item),
    .half_period_ticks (half_period_ticks),
    .res               (res)
  );

  // Hold the valid flag; advance it whenever the register may take new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_chan.valid;
    end
  end

  // Load the payload on each accepted item; hold it while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.chip_enable  = res_r.chip_enable;
  assign out_chan.serial_clock = res_r.serial_clock;
  assign out_chan.io_out       = res_r.io_out;
  assign out_chan.io_drive     = res_r.io_drive;
  assign out_chan.busy_res     = res_r.busy_res;
  assign out_chan.done_res     = res_r.done_res;
  assign out_chan.read_data    = res_r.read_data;
endmodule
`default_nettype wire

// ----- rtl/tws_checker.sv -----
// Port-level checker for the three-wire serial master and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tws_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        chip_enable,
  input wire logic                        serial_clock,
  input wire logic                        io_out,
  input wire logic                        io_drive,
  input wire logic                        busy_res,
  input wire logic                        done_res,
  input wire logic [tws_pkg::BYTE_W-1:0]  read_data,
  input wire logic                        cfg_psel,
  input wire logic                        cfg_penable,
  input wire logic                        cfg_pwrite,
  input wire logic [tws_pkg::PDATA_W-1:0] cfg_pwdata,
  input wire logic [tws_pkg::PDATA_W-1:0] cfg_prdata
);
  import tws_pkg::*;

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  // Stalled result stays put.
  `TWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({chip_enable, serial_clock, io_out, io_drive, busy_res, done_res, read_data}))
  // Released pin never shows a driven one.
  `TWS_ASSERT(a_io_released, clk, rst_n, !(out_valid && !io_drive && io_out))
  // Finished access leaves the link idle with the clock low.
  `TWS_ASSERT(a_done_idle, clk, rst_n, !(out_valid && done_res) || (!busy_res && !chip_enable && !serial_clock))
  // Driving or clocking only happens inside an access.
  `TWS_ASSERT(a_pins_in_access, clk, rst_n, !(out_valid && !chip_enable) || (!io_drive && !serial_clock))
  // A register write reads back on the next cycle.
  `TWS_ASSERT_NEXT(a_cfg_readback, clk, rst_n, cfg_wr, cfg_prdata[BYTE_W-1:0] == $past(cfg_pwdata[BYTE_W-1:0]))
endmodule

bind three_wire_serial_master tws_checker u_tws_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .chip_enable  (out_chan.chip_enable),
  .serial_clock (out_chan.serial_clock),
  .io_out       (out_chan.io_out),
  .io_drive     (out_chan.io_drive),
  .busy_res     (out_chan.busy_res),
  .done_res     (out_chan.done_res),
  .read_data    (out_chan.read_data),
  .cfg_psel     (cfg_psel),
  .cfg_penable  (cfg_penable),
  .cfg_pwrite   (cfg_pwrite),
  .cfg_pwdata   (cfg_pwdata),
  .cfg_prdata   (cfg_prdata)
);
`default_nettype wire
